[design/ufc_pkg.sv]
// ufc_pkg: shared constants, opcodes and helper functions for the serial
// port buffering block (ring depth, field widths, reset values).
// No dependencies.
package ufc_pkg;

  // Ring geometry
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MARGIN_W = 9;
  localparam int unsigned CMP_W    = (FILL_W > MARGIN_W) ? FILL_W : MARGIN_W;

  // Reset value of the RTS margin register
  localparam logic [MARGIN_W-1:0] RTS_MARGIN_RST = MARGIN_W'(10);

  // Derived constants
  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RING_DEPTH - 1);

  // Event codes
  localparam logic [OP_W-1:0] OP_LINE_RX   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_HOST_RD   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_HOST_WR   = OP_W'(2);
  localparam logic [OP_W-1:0] OP_TX_READY  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_IDLE_POLL = OP_W'(4);

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Free space in a ring for a given fill, at compare width
  function automatic logic [CMP_W-1:0] free_space(input logic [FILL_W-1:0] fill);
    return CMP_W'(DEPTH_FILL - fill);
  endfunction

endpackage

[design/ufc_ram.sv]
// ufc_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module ufc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/uart_fifo_flow_control.sv]
// uart_fifo_flow_control: receive and transmit byte rings with RTS/CTS
// flow control. Depends on ufc_pkg and ufc_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per item:
//   line byte received, host read, host write, transmitter ready or idle
//   poll, with rx_data_i, host_data_i and cts_i alongside op_i.
//   Output channel (out_valid_o / out_stall_i) returns one result item per
//   event: sent byte, host byte, write status, RTS level, overflow flag,
//   transmitter state and both ring levels after the event.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the RTS margin; it is
//   always ready and must only be written while the block is idle.
// Timing: a result passes the pending register, then the output register.
//   Throughput: one item per cycle unless the output stalls; pointers and
//   fill counts update at accept, as the ring entry enters its RAM's read register.
// Reset: rings empty, RTS asserted, overflow flag clear, margin 10. Ring
//   contents are not cleared, so no clearing pass is needed.
// Stall: a result waits in the output register; one more item is taken
//   into the read stage, then in_stall_o rises until the output drains.
module uart_fifo_flow_control (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ufc_pkg::MARGIN_W-1:0] cfg_data_i,
  // Event input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ufc_pkg::OP_W-1:0]     op_i,
  input  logic [ufc_pkg::BYTE_W-1:0]   rx_data_i,
  input  logic [ufc_pkg::BYTE_W-1:0]   host_data_i,
  input  logic                         cts_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         line_valid_o,
  output logic [ufc_pkg::BYTE_W-1:0]   line_data_o,
  output logic                         host_valid_o,
  output logic [ufc_pkg::BYTE_W-1:0]   host_byte_o,
  output logic                         write_accepted_o,
  output logic                         rts_o,
  output logic                         rx_overflowed_o,
  output logic                         tx_busy_o,
  output logic [ufc_pkg::FILL_W-1:0]   rx_level_o,
  output logic [ufc_pkg::FILL_W-1:0]   tx_level_o
);

  // Result flags and levels captured at accept
  typedef struct packed {
    logic                       line_valid;
    logic                       host_valid;
    logic                       write_accepted;
    logic                       rts;
    logic                       rx_overflowed;
    logic                       tx_busy;
    logic [ufc_pkg::FILL_W-1:0] rx_level;
    logic [ufc_pkg::FILL_W-1:0] tx_level;
  } status_t;

  // Control state
  logic [ufc_pkg::MARGIN_W-1:0] margin_q;
  logic [ufc_pkg::PTR_W-1:0]    rx_rd_ptr_q, rx_rd_ptr_d;
  logic [ufc_pkg::PTR_W-1:0]    rx_wr_ptr_q, rx_wr_ptr_d;
  logic [ufc_pkg::FILL_W-1:0]   rx_fill_q, rx_fill_d;
  logic                         rx_ovf_q, rx_ovf_d;
  logic [ufc_pkg::PTR_W-1:0]    tx_rd_ptr_q, tx_rd_ptr_d;
  logic [ufc_pkg::PTR_W-1:0]    tx_wr_ptr_q, tx_wr_ptr_d;
  logic [ufc_pkg::FILL_W-1:0]   tx_fill_q, tx_fill_d;
  logic                         tx_active_q, tx_active_d;
  logic                         rts_q, rts_d;

  // Pipeline
  logic    pend_valid_q;
  status_t pend_q;
  status_t stat_d;
  logic    out_valid_q;
  status_t out_q;
  logic [ufc_pkg::BYTE_W-1:0] out_line_data_q;
  logic [ufc_pkg::BYTE_W-1:0] out_host_byte_q;

  // RAM ports
  logic                       rx_we, rx_re, tx_we, tx_re;
  logic [ufc_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

  logic                       in_acc, pend_move, tx_send;
  logic                       line_valid_d, host_valid_d, wr_acc_d;
  logic [ufc_pkg::CMP_W-1:0]  margin_ext;

  assign cfg_ready_o = 1'b1;
  assign pend_move   = pend_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = pend_valid_q && out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign margin_ext  = ufc_pkg::CMP_W'(margin_q);

  // Event decode and state update
  always_comb begin
    rx_rd_ptr_d  = rx_rd_ptr_q;
    rx_wr_ptr_d  = rx_wr_ptr_q;
    rx_fill_d    = rx_fill_q;
    rx_ovf_d     = rx_ovf_q;
    tx_rd_ptr_d  = tx_rd_ptr_q;
    tx_wr_ptr_d  = tx_wr_ptr_q;
    tx_fill_d    = tx_fill_q;
    tx_active_d  = tx_active_q;
    rts_d        = rts_q;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    line_valid_d = 1'b0;
    host_valid_d = 1'b0;
    wr_acc_d     = 1'b0;
    tx_send      = (tx_fill_q != '0) && cts_i;
    if (in_acc) begin
      unique case (op_i)
        ufc_pkg::OP_LINE_RX: begin
          if (rx_fill_q != ufc_pkg::DEPTH_FILL) begin
            rx_we       = 1'b1;
            rx_wr_ptr_d = ufc_pkg::ptr_next(rx_wr_ptr_q);
            rx_fill_d   = rx_fill_q + ufc_pkg::FILL_W'(1);
            if (ufc_pkg::free_space(rx_fill_d) < margin_ext) begin
              rts_d = 1'b0;
            end
          end else begin
            rx_ovf_d = 1'b1;
          end
        end
        ufc_pkg::OP_HOST_RD: begin
          if (ufc_pkg::free_space(rx_fill_q) > margin_ext) begin
            rts_d = 1'b1;
          end
          if (rx_fill_q != '0) begin
            rx_re        = 1'b1;
            host_valid_d = 1'b1;
            rx_rd_ptr_d  = ufc_pkg::ptr_next(rx_rd_ptr_q);
            rx_fill_d    = rx_fill_q - ufc_pkg::FILL_W'(1);
            if (ufc_pkg::free_space(rx_fill_d) > margin_ext) begin
              rts_d = 1'b1;
            end
          end
        end
        ufc_pkg::OP_HOST_WR: begin
          if (tx_fill_q != ufc_pkg::DEPTH_FILL) begin
            tx_we       = 1'b1;
            wr_acc_d    = 1'b1;
            tx_wr_ptr_d = ufc_pkg::ptr_next(tx_wr_ptr_q);
            tx_fill_d   = tx_fill_q + ufc_pkg::FILL_W'(1);
          end
        end
        ufc_pkg::OP_TX_READY, ufc_pkg::OP_IDLE_POLL: begin
          // A poll only acts while the transmitter is idle
          if (op_i == ufc_pkg::OP_TX_READY || !tx_active_q) begin
            if (tx_send) begin
              tx_re        = 1'b1;
              line_valid_d = 1'b1;
              tx_active_d  = 1'b1;
              tx_rd_ptr_d  = ufc_pkg::ptr_next(tx_rd_ptr_q);
              tx_fill_d    = tx_fill_q - ufc_pkg::FILL_W'(1);
            end else begin
              tx_active_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status as seen after the event
  always_comb begin
    stat_d.line_valid     = line_valid_d;
    stat_d.host_valid     = host_valid_d;
    stat_d.write_accepted = wr_acc_d;
    stat_d.rts            = rts_d;
    stat_d.rx_overflowed  = rx_ovf_d;
    stat_d.tx_busy        = tx_active_d;
    stat_d.rx_level       = rx_fill_d;
    stat_d.tx_level       = tx_fill_d;
  end

  // Control registers and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q     <= ufc_pkg::RTS_MARGIN_RST;
      rx_rd_ptr_q  <= '0;
      rx_wr_ptr_q  <= '0;
      rx_fill_q    <= '0;
      rx_ovf_q     <= 1'b0;
      tx_rd_ptr_q  <= '0;
      tx_wr_ptr_q  <= '0;
      tx_fill_q    <= '0;
      tx_active_q  <= 1'b0;
      rts_q        <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        margin_q <= cfg_data_i;
      end
      rx_rd_ptr_q <= rx_rd_ptr_d;
      rx_wr_ptr_q <= rx_wr_ptr_d;
      rx_fill_q   <= rx_fill_d;
      rx_ovf_q    <= rx_ovf_d;
      tx_rd_ptr_q <= tx_rd_ptr_d;
      tx_wr_ptr_q <= tx_wr_ptr_d;
      tx_fill_q   <= tx_fill_d;
      tx_active_q <= tx_active_d;
      rts_q       <= rts_d;
      if (in_acc) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; RAM data joins the status in the output stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= stat_d;
    end
    if (pend_move) begin
      out_q           <= pend_q;
      out_line_data_q <= pend_q.line_valid ? tx_rdata : '0;
      out_host_byte_q <= pend_q.host_valid ? rx_rdata : '0;
    end
  end

  // Receive ring storage
  ufc_ram #(
    .WIDTH (ufc_pkg::BYTE_W),
    .DEPTH (ufc_pkg::RING_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_ptr_q),
    .wdata_i (rx_data_i),
    .re_i    (rx_re),
    .raddr_i (rx_rd_ptr_q),
    .rdata_o (rx_rdata)
  );

  // Transmit ring storage
  ufc_ram #(
    .WIDTH (ufc_pkg::BYTE_W),
    .DEPTH (ufc_pkg::RING_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_ptr_q),
    .wdata_i (host_data_i),
    .re_i    (tx_re),
    .raddr_i (tx_rd_ptr_q),
    .rdata_o (tx_rdata)
  );

  // Outputs
  assign out_valid_o      = out_valid_q;
  assign line_valid_o     = out_q.line_valid;
  assign line_data_o      = out_line_data_q;
  assign host_valid_o     = out_q.host_valid;
  assign host_byte_o      = out_host_byte_q;
  assign write_accepted_o = out_q.write_accepted;
  assign rts_o            = out_q.rts;
  assign rx_overflowed_o  = out_q.rx_overflowed;
  assign tx_busy_o        = out_q.tx_busy;
  assign rx_level_o       = out_q.rx_level;
  assign tx_level_o       = out_q.tx_level;

endmodule

[design/ufc_checker.sv]
// ufc_checker: port-level assertions for uart_fifo_flow_control, bound to
// the top level. Depends on ufc_pkg.
module ufc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [ufc_pkg::MARGIN_W-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [ufc_pkg::OP_W-1:0]     op_i,
  input logic [ufc_pkg::BYTE_W-1:0]   rx_data_i,
  input logic [ufc_pkg::BYTE_W-1:0]   host_data_i,
  input logic                         cts_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         line_valid_o,
  input logic [ufc_pkg::BYTE_W-1:0]   line_data_o,
  input logic                         host_valid_o,
  input logic [ufc_pkg::BYTE_W-1:0]   host_byte_o,
  input logic                         write_accepted_o,
  input logic                         rts_o,
  input logic                         rx_overflowed_o,
  input logic                         tx_busy_o,
  input logic [ufc_pkg::FILL_W-1:0]   rx_level_o,
  input logic [ufc_pkg::FILL_W-1:0]   tx_level_o
);

  // A stalled item stays on the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rx_level_o))
    else $error("stalled output item dropped or changed");

  // Overflow flag is sticky across result items
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_overflowed_o |=> rx_overflowed_o)
    else $error("receive overflow flag cleared");

  // A byte handed to the line leaves the transmitter active
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_valid_o |-> tx_busy_o)
    else $error("byte sent while transmitter idle");

  // A result without a valid host read carries a zero host byte
  a_host_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !host_valid_o |-> host_byte_o == '0)
    else $error("host byte without a valid read");

endmodule

bind uart_fifo_flow_control ufc_checker u_ufc_checker (.*);
